@@ src/mmch_pkg.sv @@
// ----------------------------------------------------------------------------
// mmch_pkg: shared types and the arctangent table
// Result word layout, back-end state codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package mmch_pkg;

    localparam int OUT_W       = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_W      = 23;
    localparam int DEG_UNIT_BITS = 16;

    typedef struct packed {
        logic [2:0]        flat_axes;
        logic              heading_held;
        logic [OUT_W-1:0]  heading;
        logic [OUT_W-1:0]  norm_z;
        logic [OUT_W-1:0]  norm_y;
        logic [OUT_W-1:0]  norm_x;
    } t_result;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_HEAD,
        B_CORDIC,
        B_ANGLE,
        B_OUT
    } t_bstate;

    // atan(2^-i) in 2^-16 degree units.
    function automatic logic [ATAN_W-1:0] atan_tab(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ src/magnetometer_minmax_calibrate_heading.sv @@
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibrate_heading: min/max calibration and heading
// Learns per-axis extremes, then normalizes samples and computes a heading.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the slave stream, one word per three-axis reading. The
// first calibration_samples words after reset only widen the learned minimum
// and maximum of each axis and produce no output. Every later word produces
// one output word on the master stream with the three normalized axes, the
// heading, a held flag and the per-axis flat flags.
// The calibration count is written through i_cfg_we/i_cfg_wdata; the user
// must write it only while the block is idle, as the block does not enforce
// this. Reset sets it to 10000 and clears all learned extremes. An output
// word passes through these steps: it is taken from the queue, each of the
// three bit-serial dividers produces its quotient one bit at a time, the
// quotients are saturated, the CORDIC runs one step per cycle, the angle is
// rounded and the word is offered in the output state. A held heading skips
// the CORDIC and rounding. Words are processed one at a time, so the back
// end takes a new word from the queue only after the receiver has taken the
// last result; a two-word queue lets the input keep accepting while a result
// waits. When the receiver stalls, the result holds in its register, the
// queue fills, and then tready drops.
// Calibration words are always accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module magnetometer_minmax_calibrate_heading #(
    parameter int SAMPLE_BITS         = 16,
    parameter int NORM_FRACTION_BITS  = 14,
    parameter int ANGLE_FRACTION_BITS = 7,
    parameter int CORDIC_STEPS        = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // raw_x, raw_y, raw_z from the lowest bit up.
    input  wire logic [47:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // norm_x, norm_y, norm_z, heading from the lowest bit up.
    output logic [63:0]      o_m_tdata,
    // heading_held, flat_axes from the lowest bit up.
    output logic [3:0]       o_m_tuser
);
    import mmch_pkg::*;

    localparam int QW = 9 * SAMPLE_BITS;

    logic          w_push, w_pop, w_full, w_empty;
    logic [QW-1:0] w_push_data, w_q_data;
    t_result       w_res;

    mmch_front #(.SB(SAMPLE_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_data      (i_s_tdata),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    mmch_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    mmch_back #(
        .SB (SAMPLE_BITS),
        .NF (NORM_FRACTION_BITS),
        .AF (ANGLE_FRACTION_BITS),
        .CS (CORDIC_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_res     (w_res)
    );

    assign o_m_tdata = {w_res.heading, w_res.norm_z, w_res.norm_y, w_res.norm_x};
    assign o_m_tuser = {w_res.flat_axes, w_res.heading_held};

endmodule

`default_nettype wire

@@ src/mmch_front.sv @@
// ----------------------------------------------------------------------------
// mmch_front: sample intake and calibration
// Learns per-axis extremes, then forwards samples with their offset and range.
// ----------------------------------------------------------------------------
`default_nettype none

module mmch_front #(
    parameter int SB = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [15:0]      i_cfg_wdata,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [47:0]      i_data,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output logic [9*SB-1:0]       o_push_data
);
    import mmch_pkg::*;

    logic [15:0]   r_cal;
    logic [15:0]   r_seen;
    logic [SB-1:0] r_min [3];
    logic [SB-1:0] r_max [3];
    logic [SB-1:0] w_s   [3];
    logic          w_calibrating;
    logic          w_accept;

    always_comb begin
        logic [SB+15:0] t;
        for (int k = 0; k < 3; k++) begin
            t = {{SB{1'b0}}, i_data[16*k +: 16]};
            w_s[k] = t[SB-1:0];
        end
    end

    assign w_calibrating = (r_seen < r_cal);
    assign o_ready       = w_calibrating || !i_q_full;
    assign w_accept      = i_valid && o_ready;
    assign o_push        = w_accept && !w_calibrating;

    // Per axis: sample, minimum, range, lowest axis first.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_push_data[3*SB*k +: SB]        = w_s[k];
            o_push_data[3*SB*k + SB +: SB]   = r_min[k];
            o_push_data[3*SB*k + 2*SB +: SB] = r_max[k] - r_min[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal  <= 16'd10000;
            r_seen <= 16'd0;
            for (int k = 0; k < 3; k++) begin
                r_min[k] <= '0;
                r_max[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cal <= i_cfg_wdata;
            end
            if (w_accept && w_calibrating) begin
                r_seen <= r_seen + 16'd1;
                for (int k = 0; k < 3; k++) begin
                    if (r_seen == 16'd0) begin
                        r_min[k] <= w_s[k];
                        r_max[k] <= w_s[k];
                    end else begin
                        if (w_s[k] > r_max[k]) r_max[k] <= w_s[k];
                        if (w_s[k] < r_min[k]) r_min[k] <= w_s[k];
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ src/mmch_queue.sv @@
// ----------------------------------------------------------------------------
// mmch_queue: two-entry queue
// Decouples sample intake from the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mmch_queue #(
    parameter int W = 144
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_full,
    output logic              o_empty
);
    import mmch_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= !r_wptr;
            if (i_pop)  r_rptr <= !r_rptr;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

`default_nettype wire

@@ src/mmch_back.sv @@
// ----------------------------------------------------------------------------
// mmch_back: normalization and heading
// Three bit-serial dividers, then a vectoring CORDIC, then a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmch_back #(
    parameter int SB = 16,
    parameter int NF = 14,
    parameter int AF = 7,
    parameter int CS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_empty,
    input  wire logic [9*SB-1:0]   i_q_data,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output mmch_pkg::t_result      o_res
);
    import mmch_pkg::*;

    localparam int D     = SB + NF + 4;
    localparam int RW    = SB + 2;
    localparam int DCW   = $clog2(D + 1);
    localparam int STEPS = (CS > ATAN_ENTRIES) ? ATAN_ENTRIES : CS;
    localparam int SCW   = $clog2(STEPS + 1);
    localparam int CW    = 27;
    localparam int ZW    = 26;
    localparam int AW    = 28;
    localparam int SH    = DEG_UNIT_BITS - AF;
    localparam logic signed [AW-1:0] LIM  = AW'(180 * (1 << AF));
    localparam logic signed [AW-1:0] BASE = AW'(180 * (1 << DEG_UNIT_BITS));

    t_bstate r_state, n_state;

    logic [D-1:0]         r_dvd [3];
    logic [RW-1:0]        r_rem [3];
    logic [SB:0]          r_dvs [3];
    logic                 r_neg [3];
    logic                 r_flat [3];
    logic [DCW-1:0]       r_dcnt;
    logic [SCW-1:0]       r_scnt;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic signed [AW-1:0] r_base;
    logic [15:0]          r_last;
    t_result              r_res;

    logic [D-1:0]         w_dvd0 [3];
    logic [SB+1:0]        w_mag  [3];
    logic                 w_neg0 [3];
    logic [RW-1:0]        w_rsh  [3];
    logic                 w_ge   [3];
    logic [15:0]          w_norm [3];
    logic                 w_held;
    logic signed [CW-1:0] w_ix, w_iy;
    logic signed [AW-1:0] w_ibase;
    logic [15:0]          w_head;

    assign o_pop   = (r_state == B_IDLE) && !i_q_empty;
    assign o_valid = (r_state == B_OUT);
    assign o_res   = r_res;

    // Division setup: |2(s-lo)-r| * 2^(NF+1) + r over 2r gives the rounded magnitude.
    always_comb begin
        logic [SB-1:0]        s, lo, rg;
        logic signed [SB+2:0] a;
        for (int k = 0; k < 3; k++) begin
            s  = i_q_data[3*SB*k +: SB];
            lo = i_q_data[3*SB*k + SB +: SB];
            rg = i_q_data[3*SB*k + 2*SB +: SB];
            a  = (($signed({3'b0, s}) - $signed({3'b0, lo})) <<< 1) - $signed({3'b0, rg});
            w_neg0[k] = a[SB+2];
            w_mag[k]  = w_neg0[k] ? (SB+2)'(0) - a[SB+1:0] : a[SB+1:0];
            w_dvd0[k] = {w_mag[k], {(NF+1){1'b0}}} + D'(rg);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rsh[k] = {r_rem[k][RW-2:0], r_dvd[k][D-1]};
            w_ge[k]  = (w_rsh[k] >= RW'(r_dvs[k]));
        end
    end

    // Saturate the quotients and prepare the CORDIC start vector.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_flat[k]) begin
                w_norm[k] = 16'd0;
            end else if (!r_neg[k]) begin
                w_norm[k] = (r_dvd[k] > D'(32767)) ? 16'h7fff : r_dvd[k][15:0];
            end else begin
                w_norm[k] = (r_dvd[k] > D'(32768)) ? 16'h8000 : 16'd0 - r_dvd[k][15:0];
            end
        end
        w_held = (w_norm[0] == 16'd0) || (w_norm[0][15] && (w_norm[1] == 16'd0));
        w_ix = $signed({{(CW-24){w_norm[0][15]}}, w_norm[0], 8'd0});
        w_iy = $signed({{(CW-24){w_norm[1][15]}}, w_norm[1], 8'd0});
        w_ibase = '0;
        if (w_norm[0][15]) begin
            w_ibase = ($signed(w_norm[1]) > 0) ? BASE : -BASE;
            w_ix = -w_ix;
            w_iy = -w_iy;
        end
    end

    // Final angle: round to AF fraction bits and clamp to +-180 degrees.
    always_comb begin
        logic signed [AW-1:0] a;
        a = r_base + AW'(r_cz) + AW'(1 << (SH - 1));
        a = a >>> SH;
        if (a > LIM)  a = LIM;
        if (a < -LIM) a = -LIM;
        if (a > AW'(32767))        a = AW'(32767);
        if (a < -AW'(32768))       a = -AW'(32768);
        w_head = a[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:   if (!i_q_empty) n_state = B_DIV;
            B_DIV:    if (r_dcnt == DCW'(1)) n_state = B_HEAD;
            B_HEAD:   n_state = w_held ? B_OUT : B_CORDIC;
            B_CORDIC: if (r_scnt == SCW'(STEPS - 1)) n_state = B_ANGLE;
            B_ANGLE:  n_state = B_OUT;
            B_OUT:    if (i_ready) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic signed [CW-1:0] dx, dy;
        logic signed [ZW-1:0] t;
        if (!i_rst_n) begin
            r_last <= 16'd0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    for (int k = 0; k < 3; k++) begin
                        r_dvd[k]  <= w_dvd0[k];
                        r_rem[k]  <= '0;
                        r_dvs[k]  <= {i_q_data[3*SB*k + 2*SB +: SB], 1'b0};
                        r_neg[k]  <= w_neg0[k];
                        r_flat[k] <= (i_q_data[3*SB*k + 2*SB +: SB] == '0);
                    end
                    r_dcnt <= DCW'(D);
                end
                B_DIV: begin
                    for (int k = 0; k < 3; k++) begin
                        r_rem[k] <= w_ge[k] ? w_rsh[k] - RW'(r_dvs[k]) : w_rsh[k];
                        r_dvd[k] <= {r_dvd[k][D-2:0], w_ge[k]};
                    end
                    r_dcnt <= r_dcnt - DCW'(1);
                end
                B_HEAD: begin
                    r_res.norm_x       <= w_norm[0];
                    r_res.norm_y       <= w_norm[1];
                    r_res.norm_z       <= w_norm[2];
                    r_res.heading_held <= w_held;
                    r_res.flat_axes    <= {r_flat[2], r_flat[1], r_flat[0]};
                    r_res.heading      <= r_last;
                    r_cx   <= w_ix;
                    r_cy   <= w_iy;
                    r_cz   <= '0;
                    r_base <= w_ibase;
                    r_scnt <= '0;
                end
                B_CORDIC: begin
                    dx = r_cy >>> r_scnt;
                    dy = r_cx >>> r_scnt;
                    t  = $signed({{(ZW-ATAN_W){1'b0}}, atan_tab(5'(r_scnt))});
                    if (!r_cy[CW-1]) begin
                        r_cx <= r_cx + dx;
                        r_cy <= r_cy - dy;
                        r_cz <= r_cz + t;
                    end else begin
                        r_cx <= r_cx - dx;
                        r_cy <= r_cy + dy;
                        r_cz <= r_cz - t;
                    end
                    r_scnt <= r_scnt + SCW'(1);
                end
                // The rounded angle lands in the result before it is offered.
                B_ANGLE: begin
                    r_res.heading <= w_head;
                    r_last        <= w_head;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire
